FILE: design/assert_macros.svh
// Assertion helpers used by the decoder core module.
// Every helper samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that is checked at every rising clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An overlapping implication: the consequent must hold in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// A non-overlapping implication: the consequent must hold in the cycle after.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

FILE: design/leb128_pkg.sv
//------------------------------------------------------------------------------
// leb128_pkg
// Types, codes and constants shared by the LEB128 decoder modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package leb128_pkg;

	// Encoding layout.
	localparam int GROUP_BITS = 7;
	localparam int NUM_GROUPS = 10;
	localparam int VALUE_BITS = 64;
	localparam int SPAN_BITS  = GROUP_BITS * NUM_GROUPS;
	localparam int CONT_POS   = 7;
	localparam int SIGN_POS   = 6;

	// Largest permitted width in bits.
	localparam logic [7:0] WIDTH_LIMIT = 8'd64;

	// Status codes of a result.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BUFFER   = 2'd1;
	localparam logic [1:0] ST_WIDTH    = 2'd2;
	localparam logic [1:0] ST_BIGWIDTH = 2'd3;

	// One input transaction.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_signed;
		logic [7:0] max_bits;
		logic       buffer_end;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [63:0] decoded_value;
		logic [3:0]  byte_count;
		logic [1:0]  status;
	} out_item_t;

	// What one decode step hands to the result register.
	typedef struct packed {
		logic      emit;
		out_item_t item;
	} step_res_t;

endpackage

`default_nettype wire

FILE: design/leb_in_reg.sv
//------------------------------------------------------------------------------
// leb_in_reg
// Input register: holds one accepted byte until the decode step takes it.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module leb_in_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire leb128_pkg::in_item_t item,
	input  wire logic                 advance,
	output logic                      valid_s1,
	output leb128_pkg::in_item_t      item_s1
);

	logic take;

	// A held byte blocks the input only while the decode step cannot take it.
	assign item_stall = valid_s1 & ~advance;
	assign take       = item_valid & ~item_stall;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

FILE: design/leb_core.sv
//------------------------------------------------------------------------------
// leb_core
// Decode state and the combinational step that folds one byte into it.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module leb_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 advance,
	input  wire leb128_pkg::in_item_t item_s1,
	output leb128_pkg::step_res_t     step
);

	// Decode state.
	logic        busy_q;
	logic [6:0]  width_q;
	logic        signed_q;
	logic [63:0] acc_q;
	logic [3:0]  count_q;

	// Working values of the step.
	logic        first;
	logic        big_width;
	logic [6:0]  eff_width;
	logic        eff_signed;
	logic [63:0] eff_acc;
	logic [3:0]  eff_count;
	logic [6:0]  shift_amt;
	logic        width_bad;
	logic [6:0]  payload;
	logic        cont;
	logic [leb128_pkg::SPAN_BITS-1:0] place_w;
	logic [leb128_pkg::SPAN_BITS-1:0] fill_w;
	logic [63:0] acc_new;
	logic [63:0] final_value;
	logic        go_on;

	// The first byte of an encoding latches the mode and starts from a clear state.
	assign first      = ~busy_q;
	assign big_width  = first & (item_s1.max_bits > leb128_pkg::WIDTH_LIMIT);
	assign eff_width  = first ? item_s1.max_bits[6:0] : width_q;
	assign eff_signed = first ? item_s1.is_signed : signed_q;
	assign eff_acc    = first ? '0 : acc_q;
	assign eff_count  = first ? '0 : count_q;

	// The shift is seven times the number of bytes already used.
	assign shift_amt = {eff_count, 3'b000} - {3'b000, eff_count};

	// Width check before the byte is used; a shift past bit 63 always fails.
	assign width_bad = (eff_signed ? (shift_amt > eff_width) : (shift_amt >= eff_width))
		| shift_amt[6];

	assign payload = item_s1.data_byte[6:0];
	assign cont    = item_s1.data_byte[leb128_pkg::CONT_POS];

	// Place the payload in its group, and mark every group above it for sign fill.
	always_comb begin
		place_w = '0;
		fill_w  = '0;
		for (int g = 0; g < leb128_pkg::NUM_GROUPS; g++) begin
			place_w[g*leb128_pkg::GROUP_BITS +: leb128_pkg::GROUP_BITS] =
				(eff_count == 4'(g)) ? payload : '0;
			fill_w[g*leb128_pkg::GROUP_BITS +: leb128_pkg::GROUP_BITS] =
				(4'(g) > eff_count) ? '1 : '0;
		end
	end

	assign acc_new     = eff_acc | place_w[63:0];
	assign final_value = (eff_signed & item_s1.data_byte[leb128_pkg::SIGN_POS])
		? (acc_new | fill_w[63:0]) : acc_new;

	// Outcome of the step.
	always_comb begin
		step.emit               = 1'b1;
		step.item.decoded_value = '0;
		step.item.byte_count    = '0;
		step.item.status        = leb128_pkg::ST_OK;
		go_on                   = 1'b0;
		if (big_width) begin
			step.item.status = leb128_pkg::ST_BIGWIDTH;
		end else if (width_bad) begin
			step.item.status = leb128_pkg::ST_WIDTH;
		end else if (!cont) begin
			step.item.decoded_value = final_value;
			step.item.byte_count    = eff_count + 4'd1;
		end else if (item_s1.buffer_end) begin
			step.item.status = leb128_pkg::ST_BUFFER;
		end else begin
			step.emit = 1'b0;
			go_on     = 1'b1;
		end
	end

	// Control state: any result returns the decoder to idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (advance) begin
			busy_q  <= go_on;
			count_q <= go_on ? (eff_count + 4'd1) : '0;
		end
	end

	// Data state of an encoding under way.
	always_ff @(posedge clk) begin
		if (advance && go_on) begin
			acc_q    <= acc_new;
			width_q  <= eff_width;
			signed_q <= eff_signed;
		end
	end

	`ASSERT_IMPL(a_err_zero, step.emit && (step.item.status != leb128_pkg::ST_OK), (step.item.decoded_value == 64'd0) && (step.item.byte_count == 4'd0), "Error result carries a value or count.")
	`ASSERT_IMPL(a_busy_count, busy_q, (count_q != 4'd0) && (count_q <= 4'd10), "Byte count out of range during an encoding.")
	`ASSERT_IMPL(a_idle_count, !busy_q, count_q == 4'd0, "Byte count not cleared while idle.")
	`ASSERT_NEXT(a_result_idle, advance && step.emit, !busy_q, "Decoder still busy after a result.")

endmodule

`default_nettype wire

FILE: design/leb_out_reg.sv
//------------------------------------------------------------------------------
// leb_out_reg
// Result register: holds one result transaction until the consumer takes it.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module leb_out_reg (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire leb128_pkg::step_res_t step,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output leb128_pkg::out_item_t      result
);

	// Valid flag: loaded on a step, cleared once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= step.emit;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && step.emit) begin
			result <= step.item;
		end
	end

endmodule

`default_nettype wire

FILE: design/leb128_decoder_top.sv
//------------------------------------------------------------------------------
// leb128_decoder_top
// LEB128 variable-length integer decoder, one encoded byte per transaction.
//------------------------------------------------------------------------------
// The decoder takes one byte per cycle while the receiver does not stall a held
// result: a byte passes through an input register, one decode step folds it
// into the accumulator and the result register holds the outcome, so a result
// is registered first in the input register and then in the result register.
// The sustained figure of one byte per cycle is set by the decode step, which
// places the seven payload bits at the current group, checks the width and
// updates the state. Only the final byte of an encoding, or a byte that ends it
// in error, gives a result; every result leaves the decoder ready for a new encoding.
`timescale 1ns / 1ps
`default_nettype none

module leb128_decoder_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire leb128_pkg::in_item_t item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output leb128_pkg::out_item_t     result
);

	logic                  valid_s1;
	leb128_pkg::in_item_t  item_s1;
	leb128_pkg::step_res_t step;
	logic                  advance;

	// The held byte is decoded when the result register is free or being emptied.
	assign advance = valid_s1 & (~result_valid | ~result_stall);

	leb_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	leb_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.step    (step)
	);

	leb_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.step         (step),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

FILE: tb/leb128_decoder_top_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// leb128_decoder_top_tb
// Self-checking testbench for the LEB128 varint decoder.
//------------------------------------------------------------------------------
// Bytes are offered on the input channel in random bursts. Each accepted
// transaction is also fed to a cycle-free model of the decoder held here,
// and every result it predicts is queued. Each accepted result transaction is
// compared field by field with the oldest queued prediction. Directed
// sequences cover single-byte values, the error codes and the longest
// encoding. A long receiver hold-off fills the pipeline. Random encodings of
// mixed widths and signedness follow, mixed with loose noise bytes.
//------------------------------------------------------------------------------

module leb128_decoder_top_tb;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 880;
	localparam int MAX_REPORTS = 40;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	leb128_pkg::in_item_t  item = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	leb128_pkg::out_item_t result;

	// Decoder model state.
	logic [63:0] enc_acc = '0;
	logic [6:0]  enc_shift = '0;
	logic [3:0]  enc_count = '0;
	logic        enc_busy = 1'b0;
	logic [6:0]  enc_width = '0;
	logic        enc_signed = 1'b0;

	leb128_pkg::out_item_t decode_queue[$];
	int        mismatch_count = 0;
	int        items_sent = 0;
	int        burst_left = 0;
	int        quiet_cycles = 0;
	int        hold_left = 0;
	logic      hold_req = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;
	int        mode_left = 0;

	leb128_decoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Return the decoder model to idle between encodings.
	function automatic void enc_idle();
		enc_acc = '0;
		enc_shift = '0;
		enc_count = '0;
		enc_busy = 1'b0;
	endfunction

	// Fold one byte into the model; returns 1 when the byte ends an encoding.
	function automatic bit decode_step(input leb128_pkg::in_item_t it,
			output leb128_pkg::out_item_t res);
		logic [63:0] value;
		logic        too_wide;
		res = '0;
		if (!enc_busy) begin
			if (it.max_bits > leb128_pkg::WIDTH_LIMIT) begin
				res.status = leb128_pkg::ST_BIGWIDTH;
				return 1'b1;
			end
			enc_idle();
			enc_width = it.max_bits[6:0];
			enc_signed = it.is_signed;
			enc_busy = 1'b1;
		end

		// The width check comes before the byte is used.
		too_wide = enc_signed ? (enc_shift > enc_width) : (enc_shift >= enc_width);
		if (too_wide || enc_shift >= 7'd64) begin
			res.status = leb128_pkg::ST_WIDTH;
			enc_idle();
			return 1'b1;
		end

		enc_acc |= {57'd0, it.data_byte[6:0]} << enc_shift;
		enc_count += 4'd1;

		if (enc_signed) begin
			enc_shift += 7'(leb128_pkg::GROUP_BITS);
			if (!it.data_byte[leb128_pkg::CONT_POS]) begin
				value = enc_acc;
				if (enc_shift < 7'd64 && it.data_byte[leb128_pkg::SIGN_POS])
					value |= ~64'd0 << enc_shift;
				res.decoded_value = value;
				res.byte_count = enc_count;
				res.status = leb128_pkg::ST_OK;
				enc_idle();
				return 1'b1;
			end
			if (it.buffer_end) begin
				res.status = leb128_pkg::ST_BUFFER;
				enc_idle();
				return 1'b1;
			end
		end else begin
			if (!it.data_byte[leb128_pkg::CONT_POS]) begin
				res.decoded_value = enc_acc;
				res.byte_count = enc_count;
				res.status = leb128_pkg::ST_OK;
				enc_idle();
				return 1'b1;
			end
			if (it.buffer_end) begin
				res.status = leb128_pkg::ST_BUFFER;
				enc_idle();
				return 1'b1;
			end
			enc_shift += 7'(leb128_pkg::GROUP_BITS);
		end
		return 1'b0;
	endfunction

	// Print one line per mismatch, up to a cap, and count all of them.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: error: %s got %0h want %0h", $time, what, got, want);
	endtask

	// Check each result transaction, then predict from each input transaction.
	always @(posedge clk) begin
		leb128_pkg::out_item_t want;
		leb128_pkg::out_item_t predicted;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (decode_queue.size() == 0) begin
					report_mismatch("unexpected result, status", 64'(result.status),
						64'd0);
				end else begin
					want = decode_queue.pop_front();
					if (result.decoded_value !== want.decoded_value)
						report_mismatch("decoded_value", result.decoded_value,
							want.decoded_value);
					if (result.byte_count !== want.byte_count)
						report_mismatch("byte_count", 64'(result.byte_count),
							64'(want.byte_count));
					if (result.status !== want.status)
						report_mismatch("status", 64'(result.status), 64'(want.status));
				end
			end
			if (item_valid && !item_stall) begin
				if (decode_step(item, predicted))
					decode_queue.push_back(predicted);
			end
		end
	end

	// Receiver: a long hold-off on request, otherwise a changing stall pattern.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			result_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(10, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE: begin
					result_stall <= 1'b0;
				end
				STALL_LIGHT: begin
					result_stall <= ($urandom_range(0, 3) == 0);
				end
				STALL_HEAVY: begin
					result_stall <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					result_stall <= ~result_stall;
				end
			endcase
		end
	end

	// Watchdog on cycles in which no transaction is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("leb128_decoder_top: mismatch");
					$finish;
				end
			end
		end
	end

	function automatic leb128_pkg::in_item_t mk(input logic [7:0] data, input logic sgn,
			input logic [7:0] width, input logic last);
		leb128_pkg::in_item_t it;
		it.data_byte = data;
		it.is_signed = sgn;
		it.max_bits = width;
		it.buffer_end = last;
		return it;
	endfunction

	// Offer one byte and wait for its transaction; gaps fall between bursts.
	task automatic send_byte(input leb128_pkg::in_item_t x);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		item <= x;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	// Single-byte encodings in both modes.
	task automatic test_single_bytes();
		send_byte(mk(8'h00, 1'b0, 8'd64, 1'b0));
		send_byte(mk(8'h7F, 1'b0, 8'd64, 1'b1));
		send_byte(mk(8'h7F, 1'b1, 8'd64, 1'b0));
		send_byte(mk(8'h40, 1'b1, 8'd64, 1'b0));
		// A signed width of zero still admits the first byte.
		send_byte(mk(8'h01, 1'b1, 8'd0, 1'b0));
	endtask

	// Width above the limit and width running out in both modes.
	task automatic test_width_errors();
		send_byte(mk(8'h12, 1'b0, 8'd255, 1'b0));
		send_byte(mk(8'h12, 1'b1, 8'd65, 1'b0));
		send_byte(mk(8'h05, 1'b0, 8'd0, 1'b0));
		send_byte(mk(8'h80, 1'b0, 8'd7, 1'b0));
		send_byte(mk(8'h01, 1'b0, 8'd7, 1'b0));
		send_byte(mk(8'h80, 1'b1, 8'd7, 1'b0));
		send_byte(mk(8'h80, 1'b1, 8'd7, 1'b0));
		send_byte(mk(8'h01, 1'b1, 8'd7, 1'b0));
	endtask

	// The buffer ending inside an encoding and on its final byte.
	task automatic test_buffer_end();
		send_byte(mk(8'hFF, 1'b0, 8'd64, 1'b1));
		send_byte(mk(8'h80, 1'b1, 8'd64, 1'b1));
		send_byte(mk(8'h2A, 1'b0, 8'd64, 1'b1));
	endtask

	// Ten bytes that set every bit of the value.
	task automatic test_longest();
		repeat (9) send_byte(mk(8'hFF, 1'b0, 8'd64, 1'b0));
		send_byte(mk(8'h01, 1'b0, 8'd64, 1'b0));
	endtask

	// Hold the receiver off while the sender keeps offering final bytes.
	task automatic test_backpressure();
		item_valid <= 1'b0;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		repeat (40)
			send_byte(mk(8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 8'd64,
				1'b0));
	endtask

	// One random encoding, mostly sized to fit its width, sometimes not.
	task automatic send_encoding();
		logic       sgn;
		logic [7:0] width;
		int         max_len;
		int         lim;
		int         len;
		logic [7:0] data;
		logic       last;
		sgn = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 7))
			0: width = 8'($urandom_range(65, 255));
			1, 2: width = 8'($urandom_range(0, 64));
			3: width = 8'd8;
			4: width = 8'd16;
			5: width = 8'd32;
			default: width = 8'd64;
		endcase
		max_len = sgn ? width / 7 + 1 : (width + 6) / 7;
		if (max_len > 10)
			max_len = 10;
		if (max_len == 0)
			max_len = 1;
		if ($urandom_range(0, 4) == 0) begin
			len = $urandom_range(1, 11);
		end else begin
			lim = max_len;
			if (lim > 3 && $urandom_range(0, 2) != 0)
				lim = 3;
			len = $urandom_range(1, lim);
		end
		for (int i = 0; i < len; i++) begin
			data = 8'($urandom_range(0, 127));
			if (i < len - 1) begin
				data[leb128_pkg::CONT_POS] = 1'b1;
				last = ($urandom_range(0, 19) == 0);
			end else begin
				last = 1'($urandom_range(0, 1));
			end
			// Later bytes mostly repeat the settings, which are ignored mid-encoding.
			if (i != 0 && $urandom_range(0, 7) == 0)
				send_byte(mk(data, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					last));
			else
				send_byte(mk(data, sgn, width, last));
		end
	endtask

	// Random encodings with occasional runs of unstructured bytes.
	task automatic test_random();
		int target;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 6))
					send_byte(mk(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
			end else begin
				send_encoding();
			end
		end
	endtask

	// Test sequence.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_bytes();
		test_width_errors();
		test_buffer_end();
		test_longest();
		test_backpressure();
		test_random();

		item_valid <= 1'b0;
		while (decode_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("leb128_decoder_top: match");
		else
			$display("leb128_decoder_top: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/leb128_pkg.sv
design/leb_in_reg.sv
design/leb_core.sv
design/leb_out_reg.sv
design/leb128_decoder_top.sv
tb/leb128_decoder_top_tb.sv
